@@ src/olisd_pkg.sv @@
// ----------------------------------------------------------------------------
// olisd_pkg
// Shared types and codes for the ordered value list block.
// ----------------------------------------------------------------------------
package olisd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] count;
    } out_t;

endpackage

@@ src/ordered_list_insert_search_delete_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_search_delete_top
// List of signed values in insertion order with insert, search, delete
// and clear; one result item per input item.
//
//   channel   dir   ports                    item
//   s_        in    s_valid s_ready s_data   op, value
//   m_        out   m_valid m_ready m_data   status, position, count
//
// Insert and clear go from idle straight to the result state. Search reads
// and compares one entry at a time; delete then moves each later entry
// toward the head with one read and one write, so an item's length is set
// by the single read port of the entry RAM and the one compare unit.
// Reset clears the entry count and the output valid flag; no clearing pass.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_delete_top #(
    parameter int DEPTH = olisd_pkg::DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  olisd_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output olisd_pkg::out_t m_data
);
    import olisd_pkg::*;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg,  m_data_next;
    logic res_valid;
    logic res_ready;
    out_t res_data;

    olisd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/olisd_ram.sv @@
// ----------------------------------------------------------------------------
// olisd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olisd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/olisd_ctrl.sv @@
// ----------------------------------------------------------------------------
// olisd_ctrl
// Sequencer for the list: walks the store through one compare unit and
// closes the gap after a delete, one entry move per shift read and write.
// ----------------------------------------------------------------------------
module olisd_ctrl #(
    parameter int DEPTH = olisd_pkg::DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  olisd_pkg::in_t   in_data,
    output logic             res_valid,
    input  logic             res_ready,
    output olisd_pkg::out_t  res_data
);
    import olisd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_RESULT   = 3'd5;

    logic [2:0]                state_reg,  state_next;
    logic [1:0]                op_reg,     op_next;
    logic signed [VALUE_W-1:0] value_reg,  value_next;
    logic [CW-1:0]             count_reg,  count_next;
    logic [AW-1:0]             idx_reg,    idx_next;
    logic [CW-1:0]             pos_reg,    pos_next;
    logic [1:0]                status_reg, status_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic [CW-1:0]      idx_inc;
    logic               hit;

    assign idx_inc = CW'(idx_reg) + CW'(1);
    assign hit     = (mem_rdata == value_reg);

    olisd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = value_reg;
        mem_raddr   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_data.op;
                    value_next  = in_data.value;
                    pos_next    = '0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_RESULT;
                    unique case (in_data.op)
                        OP_INSERT: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = in_data.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_SEARCH, OP_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOTFOUND;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    pos_next = idx_inc;
                    if (op_reg == OP_DELETE && idx_inc < count_reg) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        if (op_reg == OP_DELETE) begin
                            count_next = count_reg - CW'(1);
                        end
                        state_next = S_RESULT;
                    end
                end else if (idx_inc == count_reg) begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESULT;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                mem_raddr  = idx_inc[AW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                idx_next  = idx_reg + AW'(1);
                if (idx_inc + CW'(1) < count_reg) begin
                    state_next = S_SHIFT_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_RESULT);
    assign res_data.status   = status_reg;
    assign res_data.position = POS_W'(pos_reg);
    assign res_data.count    = POS_W'(count_reg);

endmodule

@@ src/olisd_checker.sv @@
// ----------------------------------------------------------------------------
// olisd_checker
// Port-level checks for the ordered value list block.
// ----------------------------------------------------------------------------
module olisd_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input olisd_pkg::in_t  s_data,
    input logic            m_valid,
    input logic            m_ready,
    input olisd_pkg::out_t m_data
);
    import olisd_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before item finished");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.position == '0 && !$isunknown(s_ready))
        else $error("full status with a position");

endmodule

bind ordered_list_insert_search_delete_top olisd_checker u_olisd_checker (.*);
